@@ src/mpbe_pkg.sv @@
package mpbe_pkg;

	localparam int CoordW  = 16;
	localparam int ReasonW = 5;
	localparam int MaskW   = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 16;

	// Word widths on the stream ports, rounded up to whole bytes.
	localparam int InDataW  = 40;
	localparam int InUsedW  = 2 * CoordW + 2;
	localparam int OutDataW = 72;

	typedef enum logic [1:0] {
		ACT_MOVE   = 2'd0,
		ACT_BUTTON = 2'd1,
		ACT_STATUS = 2'd2,
		ACT_SETPOS = 2'd3
	} action_t;

	localparam logic [ReasonW-1:0] RSN_NONE       = 5'h00;
	localparam logic [ReasonW-1:0] RSN_MOVE       = 5'h01;
	localparam logic [ReasonW-1:0] RSN_LEFT_DOWN  = 5'h02;
	localparam logic [ReasonW-1:0] RSN_LEFT_UP    = 5'h04;
	localparam logic [ReasonW-1:0] RSN_RIGHT_DOWN = 5'h08;
	localparam logic [ReasonW-1:0] RSN_RIGHT_UP   = 5'h10;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MIN_X   = 3'd0,
		CFG_MAX_X   = 3'd1,
		CFG_MIN_Y   = 3'd2,
		CFG_MAX_Y   = 3'd3,
		CFG_MASK    = 3'd4,
		CFG_SEGMENT = 3'd5,
		CFG_OFFSET  = 3'd6
	} cfg_idx_t;

	// Packed so that coord_x lands in bit 0 of the word.
	typedef struct packed {
		logic              pressed;
		logic              is_left;
		logic [CoordW-1:0] coord_y;
		logic [CoordW-1:0] coord_x;
	} in_item_t;

	// Packed so that event_fire lands in bit 0 of the word.
	typedef struct packed {
		logic signed [CoordW-1:0] delta_y_out;
		logic signed [CoordW-1:0] delta_x_out;
		logic [CoordW-1:0]        pos_y_out;
		logic [CoordW-1:0]        pos_x_out;
		logic [1:0]               button_bits;
		logic [ReasonW-1:0]       event_reason;
		logic                     event_fire;
	} result_t;

	// Lower limit first, then upper, so crossed limits leave the upper one in force.
	function automatic logic [CoordW-1:0] clamp_axis(
		input logic [CoordW-1:0] v,
		input logic [CoordW-1:0] lo,
		input logic [CoordW-1:0] hi
	);
		logic [CoordW-1:0] t;
		t = v;
		if (lo != '0 && t < lo) t = lo;
		if (hi != '0 && t > hi) t = hi;
		return t;
	endfunction

endpackage

@@ src/mouse_position_button_event_unit.sv @@
// Channel   Direction  Word layout (lowest bit first)
// s_*       in         tuser: action[1:0]; tdata: coord_x, coord_y, is_left, pressed, pad
// m_*       out        tdata: event_fire, event_reason, button_bits, pos_x_out,
//                             pos_y_out, delta_x_out, delta_y_out
// cfg_*     in         cfg_we, cfg_index (register 0..6), cfg_data
//
// One word per clock unless m_tready stalls the result register: a word is held in the
// input register and is then computed against the pointer state into the result
// register in a single step. m_tvalid rises when that step loads the result register.
// arst_n clears the pointer state, the limits, mask and handler, and both valid flags.
// A stall on m_tready holds the result register; the input register keeps taking a
// word as long as it can move forward, so the input side stalls only when both are full.
module mouse_position_button_event_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// coord_x[15:0], coord_y[31:16], is_left[32], pressed[33], zero pad[39:34]
	input  logic [mpbe_pkg::InDataW-1:0]     s_tdata,
	// action[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// event_fire[0], event_reason[5:1], button_bits[7:6], pos_x_out[23:8],
	// pos_y_out[39:24], delta_x_out[55:40], delta_y_out[71:56]
	output logic [mpbe_pkg::OutDataW-1:0]    m_tdata,
	input  logic                             cfg_we,
	input  logic [mpbe_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [mpbe_pkg::CfgW-1:0]        cfg_data
);

	localparam int W = mpbe_pkg::CoordW;

	logic [W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [W-1:0] seg_q, ofs_q;
	logic [mpbe_pkg::MaskW-1:0] mask_q;

	logic [W-1:0]        pos_x_q, pos_y_q;
	logic signed [W-1:0] mot_x_q, mot_y_q;
	logic                left_q, right_q;

	logic                valid_s1;
	mpbe_pkg::in_item_t  item_s1;
	mpbe_pkg::action_t   action_s1;

	logic                out_valid_q;
	mpbe_pkg::result_t   out_q;

	logic                advance;
	mpbe_pkg::result_t   res;
	logic [W-1:0]        nx, ny;
	logic signed [W-1:0] mx, my;
	logic                nleft, nright;
	logic [mpbe_pkg::ReasonW-1:0] reason;
	logic                has_handler;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
			mask_q  <= '0;
			seg_q   <= '0;
			ofs_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mpbe_pkg::CFG_MIN_X:   min_x_q <= cfg_data;
				mpbe_pkg::CFG_MAX_X:   max_x_q <= cfg_data;
				mpbe_pkg::CFG_MIN_Y:   min_y_q <= cfg_data;
				mpbe_pkg::CFG_MAX_Y:   max_y_q <= cfg_data;
				mpbe_pkg::CFG_MASK:    mask_q  <= cfg_data[mpbe_pkg::MaskW-1:0];
				mpbe_pkg::CFG_SEGMENT: seg_q   <= cfg_data;
				mpbe_pkg::CFG_OFFSET:  ofs_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1   <= s_tdata[mpbe_pkg::InUsedW-1:0];
			action_s1 <= mpbe_pkg::action_t'(s_tuser);
		end
	end

	always_comb begin
		nx     = pos_x_q;
		ny     = pos_y_q;
		mx     = mot_x_q;
		my     = mot_y_q;
		nleft  = left_q;
		nright = right_q;
		reason = mpbe_pkg::RSN_NONE;
		case (action_s1)
			mpbe_pkg::ACT_MOVE: begin
				nx     = mpbe_pkg::clamp_axis(item_s1.coord_x, min_x_q, max_x_q);
				ny     = mpbe_pkg::clamp_axis(item_s1.coord_y, min_y_q, max_y_q);
				mx     = nx - pos_x_q;
				my     = ny - pos_y_q;
				reason = mpbe_pkg::RSN_MOVE;
			end
			mpbe_pkg::ACT_BUTTON: begin
				if (item_s1.is_left) begin
					nleft  = item_s1.pressed;
					reason = item_s1.pressed ? mpbe_pkg::RSN_LEFT_DOWN
					                         : mpbe_pkg::RSN_LEFT_UP;
				end else begin
					nright = item_s1.pressed;
					reason = item_s1.pressed ? mpbe_pkg::RSN_RIGHT_DOWN
					                         : mpbe_pkg::RSN_RIGHT_UP;
				end
			end
			mpbe_pkg::ACT_SETPOS: begin
				nx = item_s1.coord_x;
				ny = item_s1.coord_y;
			end
			default: ;
		endcase

		has_handler = (seg_q != '0) || (ofs_q != '0);

		res.event_fire   = (reason != mpbe_pkg::RSN_NONE) && has_handler &&
		                   ((mask_q[mpbe_pkg::ReasonW-1:0] & reason) == reason);
		res.event_reason = reason;
		res.button_bits  = {nright, nleft};
		res.pos_x_out    = nx;
		res.pos_y_out    = ny;
		res.delta_x_out  = mx;
		res.delta_y_out  = my;
	end

	// Pointer state commits together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			mot_x_q <= '0;
			mot_y_q <= '0;
			left_q  <= 1'b0;
			right_q <= 1'b0;
		end else if (advance) begin
			pos_x_q <= nx;
			pos_y_q <= ny;
			mot_x_q <= mx;
			mot_y_q <= my;
			left_q  <= nleft;
			right_q <= nright;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	a_fire_needs_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.event_fire |-> out_q.event_reason != mpbe_pkg::RSN_NONE)
		else $error("event raised without a reason");

	a_reason_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(out_q.event_reason))
		else $error("more than one reason bit set");

	a_state_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_q.pos_x_out == pos_x_q && out_q.pos_y_out == pos_y_q &&
		            out_q.button_bits == {right_q, left_q})
		else $error("result does not match committed pointer state");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a word while blocked");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
	import mpbe_pkg::*;

	// Index 7 has no register behind it; writes to it must leave the block unchanged.
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;
	localparam int StallLimit = 5000;
	localparam int ChunkWords = 120;

	typedef struct {
		logic               fire;
		logic [ReasonW-1:0] reason;
		logic [1:0]         buttons;
		logic [CoordW-1:0]  pos_x;
		logic [CoordW-1:0]  pos_y;
		logic [CoordW-1:0]  delta_x;
		logic [CoordW-1:0]  delta_y;
	} pointer_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// coord_x, coord_y, is_left, pressed, zero pad
	logic [InDataW-1:0]  s_tdata = '0;
	// action
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// event_fire, event_reason, button_bits, pos_x_out, pos_y_out, delta_x_out, delta_y_out
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;

	// Our own copy of the configuration and pointer state.
	logic [CoordW-1:0] lim_min_x = '0, lim_max_x = '0, lim_min_y = '0, lim_max_y = '0;
	logic [MaskW-1:0]  ev_mask = '0;
	logic [CoordW-1:0] hnd_seg = '0, hnd_off = '0;
	logic [CoordW-1:0] cur_x = '0, cur_y = '0, last_dx = '0, last_dy = '0;
	logic              held_left = 1'b0, held_right = 1'b0;

	pointer_result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int words_sent = 0;
	int results_checked = 0;
	int events_fired = 0;
	int error_count = 0;
	int stall_cycles = 0;

	mouse_position_button_event_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [CoordW-1:0] bound_coord(input logic [CoordW-1:0] v,
			input logic [CoordW-1:0] lo, input logic [CoordW-1:0] hi);
		logic [CoordW-1:0] r;
		r = (lo != '0 && v < lo) ? lo : v;
		if (hi != '0 && r > hi) r = hi;
		return r;
	endfunction

	// Advances the pointer state by one word and returns the result it should produce.
	function automatic pointer_result_t step_pointer(input action_t act,
			input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
			input logic lft, input logic prs);
		pointer_result_t r;
		logic [CoordW-1:0] nx;
		logic [CoordW-1:0] ny;
		r.reason = RSN_NONE;
		case (act)
			ACT_MOVE: begin
				nx = bound_coord(cx, lim_min_x, lim_max_x);
				ny = bound_coord(cy, lim_min_y, lim_max_y);
				last_dx = nx - cur_x;
				last_dy = ny - cur_y;
				cur_x = nx;
				cur_y = ny;
				r.reason = RSN_MOVE;
			end
			ACT_BUTTON: begin
				if (lft) begin
					held_left = prs;
					r.reason = prs ? RSN_LEFT_DOWN : RSN_LEFT_UP;
				end else begin
					held_right = prs;
					r.reason = prs ? RSN_RIGHT_DOWN : RSN_RIGHT_UP;
				end
			end
			ACT_SETPOS: begin
				cur_x = cx;
				cur_y = cy;
			end
			default: ;
		endcase
		r.fire = (r.reason != RSN_NONE)
			&& ((ev_mask & MaskW'(r.reason)) == MaskW'(r.reason))
			&& (hnd_seg != '0 || hnd_off != '0);
		r.buttons = {held_right, held_left};
		r.pos_x = cur_x;
		r.pos_y = cur_y;
		r.delta_x = last_dx;
		r.delta_y = last_dy;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [CoordW-1:0] want,
			input logic [CoordW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Outputs and handshakes are stable at the falling edge, so a word seen here is the
	// word taken at the next rising edge.
	always @(negedge clk) begin : check_output
		pointer_result_t want;
		pointer_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.fire = m_tdata[0];
			got.reason = m_tdata[5:1];
			got.buttons = m_tdata[7:6];
			got.pos_x = m_tdata[23:8];
			got.pos_y = m_tdata[39:24];
			got.delta_x = m_tdata[55:40];
			got.delta_y = m_tdata[71:56];
			if (pending_results.size() == 0) begin
				$display("%0t: result word %h arrived with nothing expected", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("event_fire", CoordW'(want.fire), CoordW'(got.fire));
				compare_field("event_reason", CoordW'(want.reason), CoordW'(got.reason));
				compare_field("button_bits", CoordW'(want.buttons), CoordW'(got.buttons));
				compare_field("pos_x_out", want.pos_x, got.pos_x);
				compare_field("pos_y_out", want.pos_y, got.pos_y);
				compare_field("delta_x_out", want.delta_x, got.delta_x);
				compare_field("delta_y_out", want.delta_y, got.delta_y);
				results_checked++;
				if (got.fire === 1'b1) events_fired++;
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= StallLimit) begin
			$display("%0t: no word moved for %0d cycles", $time, StallLimit);
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic send_word(input action_t act, input logic [CoordW-1:0] cx,
			input logic [CoordW-1:0] cy, input logic lft, input logic prs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(InDataW - InUsedW){1'b0}}, prs, lft, cy, cx};
		s_tuser <= act;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		pending_results.push_back(step_pointer(act, cx, cy, lft, prs));
		words_sent++;
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_MIN_X:   lim_min_x = val;
			CFG_MAX_X:   lim_max_x = val;
			CFG_MIN_Y:   lim_min_y = val;
			CFG_MAX_Y:   lim_max_y = val;
			CFG_MASK:    ev_mask = val[MaskW-1:0];
			CFG_SEGMENT: hnd_seg = val;
			CFG_OFFSET:  hnd_off = val;
			default: ;
		endcase
	endtask

	// All registers still at reset: no clamping and no handler.
	task automatic test_reset_defaults();
		send_word(ACT_MOVE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_word(ACT_MOVE, 16'h0000, 16'h0000, 1'b1, 1'b1);
		send_word(ACT_BUTTON, 16'h0000, 16'h0000, 1'b1, 1'b1);
		send_word(ACT_BUTTON, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		send_word(ACT_STATUS, 16'h5A5A, 16'hA5A5, 1'b1, 1'b0);
		send_word(ACT_SETPOS, 16'h1234, 16'hABCD, 1'b0, 1'b1);
		send_word(ACT_STATUS, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
		send_word(ACT_BUTTON, 16'h8000, 16'h0001, 1'b1, 1'b0);
		send_word(ACT_BUTTON, 16'h0001, 16'h8000, 1'b0, 1'b0);
		wait_results_done();
	endtask

	// Clamping on both axes with the handler reachable through the offset alone.
	task automatic test_limits_and_mask();
		write_reg(CFG_MASK, 16'h001F);
		write_reg(CFG_SEGMENT, 16'h0000);
		write_reg(CFG_OFFSET, 16'hFFFF);
		write_reg(CFG_MIN_X, 16'd100);
		write_reg(CFG_MAX_X, 16'd200);
		write_reg(CFG_MIN_Y, 16'h8000);
		write_reg(CFG_MAX_Y, 16'hFFFF);
		send_word(ACT_MOVE, 16'd50, 16'h0010, 1'b0, 1'b0);
		send_word(ACT_MOVE, 16'd300, 16'hFFFF, 1'b0, 1'b0);
		send_word(ACT_MOVE, 16'd150, 16'h9000, 1'b1, 1'b1);
		send_word(ACT_BUTTON, 16'd0, 16'd0, 1'b1, 1'b1);
		send_word(ACT_BUTTON, 16'd0, 16'd0, 1'b0, 1'b0);
		send_word(ACT_SETPOS, 16'd0, 16'd0, 1'b0, 1'b0);
		wait_results_done();
	endtask

	// Crossed limits leave the upper one in force; only the low five mask bits count,
	// and a write to the unused index changes nothing.
	task automatic test_crossed_and_handler();
		write_reg(CFG_MIN_X, 16'd500);
		write_reg(CFG_MAX_X, 16'd300);
		write_reg(CFG_MIN_Y, 16'hFFFF);
		write_reg(CFG_MAX_Y, 16'h0001);
		write_reg(CFG_MASK, 16'h00E0);
		write_reg(CFG_SEGMENT, 16'hFFFF);
		write_reg(CFG_OFFSET, 16'h0000);
		write_reg(CFG_UNUSED, 16'hFFFF);
		send_word(ACT_MOVE, 16'd400, 16'd7, 1'b0, 1'b0);
		send_word(ACT_MOVE, 16'd0, 16'hFFFF, 1'b0, 1'b0);
		send_word(ACT_BUTTON, 16'd0, 16'd0, 1'b1, 1'b0);
		wait_results_done();
		write_reg(CFG_MASK, 16'h0002);
		write_reg(CFG_SEGMENT, 16'h0000);
		send_word(ACT_BUTTON, 16'd0, 16'd0, 1'b1, 1'b1);
		wait_results_done();
		write_reg(CFG_SEGMENT, 16'h0001);
		send_word(ACT_BUTTON, 16'd0, 16'd0, 1'b1, 1'b1);
		send_word(ACT_BUTTON, 16'd0, 16'd0, 1'b1, 1'b0);
		wait_results_done();
	endtask

	function automatic logic [CoordW-1:0] pick_limit();
		case ($urandom_range(5))
			0, 1: return '0;
			2: return 16'h0001;
			3: return '1;
			default: return CoordW'($urandom());
		endcase
	endfunction

	// Values near the active limits are favored so both clamp edges get exercised.
	function automatic logic [CoordW-1:0] pick_coord(input logic [CoordW-1:0] lo,
			input logic [CoordW-1:0] hi);
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return lo + CoordW'($urandom_range(2)) - 16'd1;
			3: return hi + CoordW'($urandom_range(2)) - 16'd1;
			default: return CoordW'($urandom());
		endcase
	endfunction

	task automatic pick_config();
		logic [CfgW-1:0] mask_val;
		write_reg(CFG_MIN_X, pick_limit());
		write_reg(CFG_MAX_X, pick_limit());
		write_reg(CFG_MIN_Y, pick_limit());
		write_reg(CFG_MAX_Y, pick_limit());
		case ($urandom_range(3))
			0: mask_val = 16'h00FF;
			1: mask_val = 16'h001F;
			2: mask_val = 16'h0000;
			default: mask_val = CfgW'($urandom_range(255));
		endcase
		write_reg(CFG_MASK, mask_val);
		write_reg(CFG_SEGMENT, $urandom_range(1) ? 16'h0000 : CfgW'($urandom()));
		write_reg(CFG_OFFSET, $urandom_range(1) ? 16'h0000 : CfgW'($urandom()));
		if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, CfgW'($urandom()));
	endtask

	task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			if (i % ChunkWords == 0) begin
				wait_results_done();
				pick_config();
			end else if ($urandom_range(59) == 0) begin
				// Let the pipeline run dry before the next word.
				wait_results_done();
			end
			send_word(action_t'($urandom_range(3)), pick_coord(lim_min_x, lim_max_x),
				pick_coord(lim_min_y, lim_max_y), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end
		wait_results_done();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_limits_and_mask();
		test_crossed_and_handler();
		test_random_traffic(567, 18, 81);
		test_random_traffic(567, 81, 18);
		test_random_traffic(566, 0, 0);
		repeat (8) @(posedge clk);
		$display("Covered %0d words in, %0d results compared, %0d handler events raised.",
			words_sent, results_checked, events_fired);
		$display("Moves, buttons, status and set position ran under changing limits, "
			, "masks and handlers with three idle mixes.");
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/mpbe_pkg.sv
src/mouse_position_button_event_unit.sv
dv/tb_top.sv
